// ----- rtl/core/glq_pkg.sv -----
// Shared types, constants and helpers for the glyph quad layout block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package glq_pkg;

    // Table depth default and the newline character
    localparam int GLYPH_COUNT_DEF = 256;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Widths fixed by the item fields
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Item kinds carried by the mode field
    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_CHAR  = 2'd2
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X     = 3'd0,
        REG_START_Y     = 3'd1,
        REG_RIGHT_LIMIT = 3'd2,
        REG_GLYPH_SCALE = 3'd3,
        REG_LINE_HEIGHT = 3'd4
    } cfg_reg_t;

    // Vertex slots within one glyph quad, in emission order
    typedef enum logic [2:0] {
        VTX_LEFT_UP    = 3'd0,
        VTX_RIGHT_UP   = 3'd1,
        VTX_LEFT_DOWN  = 3'd2,
        VTX_LEFT_DOWN2 = 3'd3,
        VTX_RIGHT_DOWN = 3'd4,
        VTX_LAST       = 3'd5
    } vtx_t;

    // One glyph metric table entry (64 bits)
    typedef struct packed {
        logic [11:0]        ax;
        logic [11:0]        ay;
        logic [7:0]         w;
        logic [7:0]         h;
        logic signed [7:0]  ox;
        logic signed [7:0]  oy;
        logic [7:0]         adv;
    } glq_entry_t;

    // Scaled metrics of one item, handed from the multiply stage to the pen stage
    typedef struct packed {
        mode_t              mode;
        logic               newline;
        logic               in_range;
        logic [31:0]        p_adv;
        logic signed [31:0] p_ox;
        logic signed [31:0] p_oy;
        logic [31:0]        p_w;
        logic [31:0]        p_h;
        logic [31:0]        p_lh;
        logic [11:0]        ax;
        logic [11:0]        ay;
        logic [7:0]         w;
        logic [7:0]         h;
    } glq_prod_t;

    // Texture corners of one quad
    typedef struct packed {
        logic [12:0] tl;
        logic [12:0] tr;
        logic [12:0] tu;
        logic [12:0] td;
    } glq_tex_t;

    // Glyph placed at its effective pen position
    typedef struct packed {
        logic signed [31:0] pen_x;
        logic signed [31:0] pen_y;
        logic signed [31:0] p_ox;
        logic signed [31:0] p_oy;
        logic [31:0]        p_w;
        logic [31:0]        p_h;
        glq_tex_t           tex;
    } glq_quad_t;

    // Finished quad corners
    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic signed [31:0] up;
        logic signed [31:0] down;
        glq_tex_t           tex;
    } glq_vert_t;

    // Clamp a 34-bit signed sum to the signed 32-bit range
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
        begin
            r = v[31:0];
        end
        else if (v[33])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // Sign-extend a 32-bit value to 34 bits
    function automatic logic signed [33:0] sext34(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    // Zero-extend a 32-bit value to 34 bits
    function automatic logic signed [33:0] zext34(input logic [31:0] v);
        return {2'b00, v};
    endfunction

endpackage

// ----- rtl/core/glq_table.sv -----
// Glyph metric table: single-port write, one registered read port.
// Depends on glq_pkg for the entry type.
`timescale 1ns / 1ps

module glq_table
    import glq_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int IDX_W = $clog2(GLYPH_COUNT)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  glq_entry_t       wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output glq_entry_t       rd_data
);

    glq_entry_t glyph_mem [GLYPH_COUNT];
    glq_entry_t rd_data_reg;

    // Write a loaded entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            glyph_mem[wr_idx] <= wr_data;
        end
    end

    // Read on request; hold the data otherwise
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= glyph_mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/glq_scale.sv -----
// Front stage: item control alongside the table read, then the scale multiplies.
// Depends on glq_pkg; fed by glq_table read data.
`timescale 1ns / 1ps

module glq_scale
    import glq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic        in_range,
    input  glq_entry_t  entry,
    input  logic [23:0] glyph_scale,
    input  logic [7:0]  line_height,
    output logic        out_valid,
    input  logic        out_ready,
    output glq_prod_t   prod
);

    logic       s1_valid_reg;
    mode_t      s1_mode_reg;
    logic       s1_nl_reg;
    logic       s1_range_reg;
    logic       s2_valid_reg;
    glq_prod_t  prod_reg;
    glq_prod_t  prod_next;
    logic       s1_go;

    logic signed [24:0] gs_s;
    logic signed [32:0] mul_ox;
    logic signed [32:0] mul_oy;

    assign s1_go    = !s2_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_go;

    // Hold item control while the table read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_mode_reg  <= mode_t'(mode);
            s1_nl_reg    <= (char_code == NEWLINE_CODE);
            s1_range_reg <= in_range;
        end
    end

    // Scale the metrics; each product is one 24x8 multiply
    assign gs_s   = $signed({1'b0, glyph_scale});
    assign mul_ox = gs_s * entry.ox;
    assign mul_oy = gs_s * entry.oy;

    always_comb
    begin
        prod_next.mode     = s1_mode_reg;
        prod_next.newline  = s1_nl_reg;
        prod_next.in_range = s1_range_reg;
        prod_next.p_adv    = {8'd0, glyph_scale} * {24'd0, entry.adv};
        prod_next.p_ox     = mul_ox[31:0];
        prod_next.p_oy     = mul_oy[31:0];
        prod_next.p_w      = {8'd0, glyph_scale} * {24'd0, entry.w};
        prod_next.p_h      = {8'd0, glyph_scale} * {24'd0, entry.h};
        prod_next.p_lh     = {8'd0, glyph_scale} * {24'd0, line_height};
        prod_next.ax       = entry.ax;
        prod_next.ay       = entry.ay;
        prod_next.w        = entry.w;
        prod_next.h        = entry.h;
    end

    // Advance into the product register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_valid_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign prod      = prod_reg;

endmodule

// ----- rtl/core/glq_pen.sv -----
// Pen stage: wrap test, newline and start handling, pen update.
// Depends on glq_pkg; passes placed glyphs on to glq_vertex.
`timescale 1ns / 1ps

module glq_pen
    import glq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  glq_prod_t          prod,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] right_limit,
    output logic               out_valid,
    input  logic               out_ready,
    output glq_quad_t          quad
);

    logic signed [31:0] pen_x_reg;
    logic signed [31:0] pen_y_reg;
    logic signed [31:0] pen_x_next;
    logic signed [31:0] pen_y_next;
    logic               s3_valid_reg;
    glq_quad_t          quad_reg;
    glq_quad_t          quad_next;

    logic               fire;
    logic               is_char;
    logic               is_nl;
    logic               wrap;
    logic signed [33:0] sum_pen;
    logic signed [33:0] sum_start;
    logic signed [33:0] limit_w;
    logic signed [33:0] step_w;
    logic signed [31:0] step_y;
    logic signed [31:0] eff_x;
    logic signed [31:0] eff_y;

    assign in_ready = !s3_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign is_nl    = (prod.mode == MODE_CHAR) && prod.newline;
    assign is_char  = (prod.mode == MODE_CHAR) && !prod.newline && prod.in_range;

    // Candidate pen moves, side by side
    assign sum_pen   = sext34(pen_x_reg) + zext34(prod.p_adv);
    assign sum_start = sext34(start_x) + zext34(prod.p_adv);
    assign limit_w   = sext34(right_limit);
    assign step_w    = sext34(pen_y_reg) - zext34(prod.p_lh);
    assign step_y    = sat34(step_w);
    assign wrap      = sum_pen > limit_w;
    assign eff_x     = wrap ? start_x : pen_x_reg;
    assign eff_y     = wrap ? step_y : pen_y_reg;

    // Select the next pen position
    always_comb
    begin
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        case (prod.mode)
            MODE_START:
            begin
                pen_x_next = start_x;
                pen_y_next = start_y;
            end
            MODE_CHAR:
            begin
                if (is_nl)
                begin
                    pen_x_next = start_x;
                    pen_y_next = step_y;
                end
                else if (is_char)
                begin
                    pen_x_next = wrap ? sat34(sum_start) : sat34(sum_pen);
                    pen_y_next = eff_y;
                end
            end
            default:
            begin
                pen_x_next = pen_x_reg;
                pen_y_next = pen_y_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end
        else if (fire)
        begin
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
        end
    end

    // Place the glyph at the effective pen
    always_comb
    begin
        quad_next.pen_x  = eff_x;
        quad_next.pen_y  = eff_y;
        quad_next.p_ox   = prod.p_ox;
        quad_next.p_oy   = prod.p_oy;
        quad_next.p_w    = prod.p_w;
        quad_next.p_h    = prod.p_h;
        quad_next.tex.tl = {1'b0, prod.ax};
        quad_next.tex.tr = {1'b0, prod.ax} + {5'd0, prod.w};
        quad_next.tex.tu = {1'b0, prod.ay};
        quad_next.tex.td = {1'b0, prod.ay} + {5'd0, prod.h};
    end

    // Pass only glyphs on; drop items that make no vertices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            s3_valid_reg <= is_char;
        end
        else if (out_ready)
        begin
            s3_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && is_char)
        begin
            quad_reg <= quad_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign quad      = quad_reg;

endmodule

// ----- rtl/core/glq_vertex.sv -----
// Vertex stages: quad corners in two saturating steps, then six-vertex emission.
// Depends on glq_pkg; fed by glq_pen.
`timescale 1ns / 1ps

module glq_vertex
    import glq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  glq_quad_t          quad,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [12:0]        tex_x,
    output logic [12:0]        tex_y,
    output logic               last
);

    logic               s4_valid_reg;
    logic signed [31:0] s4_left_reg;
    logic signed [31:0] s4_up_reg;
    logic [31:0]        s4_pw_reg;
    logic [31:0]        s4_ph_reg;
    glq_tex_t           s4_tex_reg;

    logic               ob_valid_reg;
    glq_vert_t          ob_reg;
    glq_vert_t          ob_next;
    vtx_t               cnt_reg;
    logic               ob_free;

    assign ob_free  = !ob_valid_reg || (out_ready && cnt_reg == VTX_LAST);
    assign in_ready = !s4_valid_reg || ob_free;

    // First corner step: left and top edges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s4_valid_reg <= 1'b1;
        end
        else if (ob_free)
        begin
            s4_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s4_left_reg <= sat34(sext34(quad.pen_x) + sext34(quad.p_ox));
            s4_up_reg   <= sat34(sext34(quad.pen_y) - sext34(quad.p_oy));
            s4_pw_reg   <= quad.p_w;
            s4_ph_reg   <= quad.p_h;
            s4_tex_reg  <= quad.tex;
        end
    end

    // Second corner step: right and bottom edges
    always_comb
    begin
        ob_next.left  = s4_left_reg;
        ob_next.up    = s4_up_reg;
        ob_next.right = sat34(sext34(s4_left_reg) + zext34(s4_pw_reg));
        ob_next.down  = sat34(sext34(s4_up_reg) - zext34(s4_ph_reg));
        ob_next.tex   = s4_tex_reg;
    end

    // Hold the quad and step through its six vertices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
            cnt_reg      <= VTX_LEFT_UP;
        end
        else if (s4_valid_reg && ob_free)
        begin
            ob_valid_reg <= 1'b1;
            cnt_reg      <= VTX_LEFT_UP;
        end
        else if (ob_valid_reg && out_ready)
        begin
            if (cnt_reg == VTX_LAST)
            begin
                ob_valid_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= vtx_t'(cnt_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg && ob_free)
        begin
            ob_reg <= ob_next;
        end
    end

    // Pick the corner for the current vertex
    always_comb
    begin
        case (cnt_reg)
            VTX_LEFT_UP:
            begin
                pos_x = ob_reg.left;
                pos_y = ob_reg.up;
                tex_x = ob_reg.tex.tl;
                tex_y = ob_reg.tex.tu;
            end
            VTX_RIGHT_UP:
            begin
                pos_x = ob_reg.right;
                pos_y = ob_reg.up;
                tex_x = ob_reg.tex.tr;
                tex_y = ob_reg.tex.tu;
            end
            VTX_LEFT_DOWN, VTX_LEFT_DOWN2:
            begin
                pos_x = ob_reg.left;
                pos_y = ob_reg.down;
                tex_x = ob_reg.tex.tl;
                tex_y = ob_reg.tex.td;
            end
            VTX_RIGHT_DOWN:
            begin
                pos_x = ob_reg.right;
                pos_y = ob_reg.down;
                tex_x = ob_reg.tex.tr;
                tex_y = ob_reg.tex.td;
            end
            default:
            begin
                pos_x = ob_reg.right;
                pos_y = ob_reg.up;
                tex_x = ob_reg.tex.tr;
                tex_y = ob_reg.tex.tu;
            end
        endcase
    end

    assign last      = (cnt_reg == VTX_LAST);
    assign out_valid = ob_valid_reg;

endmodule

// ----- rtl/core/glyph_quad_layout.sv -----
// Glyph quad layout: a non-newline character item in table range yields six
// vertices, sent one per cycle while out_ready is high. The single vertex port
// bounds character throughput; load, start and newline items pass at one per
// cycle behind the table read unless a later stage stalls. Reset clears the
// pen and the pipeline valids and returns the config registers to defaults;
// the glyph table is not cleared and must be loaded before use.
`timescale 1ns / 1ps

module glyph_quad_layout
    import glq_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic [7:0]            char_code,
    input  logic [11:0]           atlas_x,
    input  logic [11:0]           atlas_y,
    input  logic [7:0]            glyph_width,
    input  logic [7:0]            glyph_height,
    input  logic signed [7:0]     offset_x,
    input  logic signed [7:0]     offset_y,
    input  logic [7:0]            advance,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    pos_x,
    output logic signed [31:0]    pos_y,
    output logic [12:0]           tex_x,
    output logic [12:0]           tex_y,
    output logic                  last
);

    localparam int IDX_W = $clog2(GLYPH_COUNT);

    logic signed [31:0] start_x_reg;
    logic signed [31:0] start_y_reg;
    logic signed [31:0] right_limit_reg;
    logic [23:0]        glyph_scale_reg;
    logic [7:0]         line_height_reg;

    logic               fire;
    logic               in_range;
    glq_entry_t         wr_entry;
    glq_entry_t         rd_entry;
    logic               prod_valid;
    logic               prod_ready;
    glq_prod_t          prod;
    logic               quad_valid;
    logic               quad_ready;
    glq_quad_t          quad;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            right_limit_reg <= 32'sh7FFF_FFFF;
            glyph_scale_reg <= 24'd65536;
            line_height_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_START_X:     start_x_reg     <= cfg_data;
                REG_START_Y:     start_y_reg     <= cfg_data;
                REG_RIGHT_LIMIT: right_limit_reg <= cfg_data;
                REG_GLYPH_SCALE: glyph_scale_reg <= cfg_data[23:0];
                REG_LINE_HEIGHT: line_height_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Decode the accepted item for the table
    assign fire     = in_valid && in_ready;
    assign in_range = ({1'b0, char_code} < 9'(GLYPH_COUNT));

    always_comb
    begin
        wr_entry.ax  = atlas_x;
        wr_entry.ay  = atlas_y;
        wr_entry.w   = glyph_width;
        wr_entry.h   = glyph_height;
        wr_entry.ox  = offset_x;
        wr_entry.oy  = offset_y;
        wr_entry.adv = advance;
    end

    glq_table #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (fire && mode == MODE_LOAD && in_range),
        .wr_idx  (char_code[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (fire && mode == MODE_CHAR && in_range),
        .rd_idx  (char_code[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    glq_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .in_ready    (in_ready),
        .mode        (mode),
        .char_code   (char_code),
        .in_range    (in_range),
        .entry       (rd_entry),
        .glyph_scale (glyph_scale_reg),
        .line_height (line_height_reg),
        .out_valid   (prod_valid),
        .out_ready   (prod_ready),
        .prod        (prod)
    );

    glq_pen u_pen (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (prod_valid),
        .in_ready    (prod_ready),
        .prod        (prod),
        .start_x     (start_x_reg),
        .start_y     (start_y_reg),
        .right_limit (right_limit_reg),
        .out_valid   (quad_valid),
        .out_ready   (quad_ready),
        .quad        (quad)
    );

    glq_vertex u_vertex (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (quad_valid),
        .in_ready  (quad_ready),
        .quad      (quad),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .tex_x     (tex_x),
        .tex_y     (tex_y),
        .last      (last)
    );

endmodule

// ----- rtl/core/glq_checker.sv -----
// Port-level checks on the vertex stream of glyph_quad_layout, bound to the top.
// Depends on glq_pkg for the vertex slot codes.
`timescale 1ns / 1ps

module glq_checker
    import glq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] pos_x,
    input logic signed [31:0] pos_y,
    input logic [12:0]        tex_x,
    input logic [12:0]        tex_y,
    input logic               last
);

    vtx_t               vcnt_reg;
    logic signed [31:0] prev_x_reg;
    logic signed [31:0] prev_y_reg;
    logic [12:0]        prev_ty_reg;
    logic               out_acc;

    assign out_acc = out_valid && out_ready;

    // Track the slot of the next vertex and the last one taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg <= VTX_LEFT_UP;
        end
        else if (out_acc)
        begin
            vcnt_reg <= (vcnt_reg == VTX_LAST) ? VTX_LEFT_UP : vtx_t'(vcnt_reg + 3'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_acc)
        begin
            prev_x_reg  <= pos_x;
            prev_y_reg  <= pos_y;
            prev_ty_reg <= tex_y;
        end
    end

    // A stalled vertex holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
            && $stable(tex_x) && $stable(tex_y) && $stable(last))
        else $error("vertex changed while stalled");

    // Last marks exactly the sixth vertex of a glyph
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (last == (vcnt_reg == VTX_LAST)))
        else $error("last flag out of step with vertex count");

    // Fourth vertex repeats the position of the third
    a_dup: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && vcnt_reg == VTX_LEFT_DOWN2 |-> pos_x == prev_x_reg && pos_y == prev_y_reg)
        else $error("shared triangle corner differs");

    // Second vertex stays on the top row of the first
    a_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && vcnt_reg == VTX_RIGHT_UP |-> pos_y == prev_y_reg && tex_y == prev_ty_reg)
        else $error("top edge mismatch within quad");

endmodule

bind glyph_quad_layout glq_checker u_glq_checker (.*);

// ----- dv/tb_glyph_quad_layout.sv -----
// Self-checking testbench for glyph_quad_layout: predicts the six vertices of each glyph
// and checks them in order on the vertex port under random idling on both sides.
// Depends on glq_pkg and the glyph_quad_layout RTL.
`timescale 1ns / 1ps

module tb_glyph_quad_layout;
    import glq_pkg::*;

    localparam logic [1:0]  MODE_UNUSED    = 2'd3;
    localparam int          ITEM_TARGET    = 380;
    localparam int          CALM_FROM      = 320;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          LONG_HOLD      = 300;
    // Longest quiet stretch of a correct run is the long receiver hold plus a drain
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam logic [31:0] INT_MIN        = 32'h8000_0000;
    localparam logic [31:0] INT_MAX        = 32'h7FFF_FFFF;
    localparam longint      POS_MAX        = 64'sd2147483647;
    localparam longint      POS_MIN        = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [12:0]        tx;
        logic [12:0]        ty;
        logic               lst;
    } vertex_t;

    // Pen and table tracker; holds the vertices still owed by the block
    class quad_scoreboard;
        longint     start_x;
        longint     start_y;
        longint     right_limit;
        longint     scale;
        longint     line_h;
        longint     pen_x;
        longint     pen_y;
        glq_entry_t glyphs [256];
        vertex_t    quads [$];
        int         errors;

        function new();
            start_x     = 0;
            start_y     = 0;
            right_limit = POS_MAX;
            scale       = 65536;
            line_h      = 0;
            pen_x       = 0;
            pen_y       = 0;
            errors      = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > POS_MAX)
            begin
                return POS_MAX;
            end
            if (v < POS_MIN)
            begin
                return POS_MIN;
            end
            return v;
        endfunction

        function int pending();
            return quads.size();
        endfunction

        // Drop one scaled line and return to the start column
        function void line_feed();
            pen_y = clamp32(pen_y - scale * line_h);
            pen_x = start_x;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            logic signed [31:0] sd;
            sd = data;
            case (idx)
                REG_START_X:     start_x = sd;
                REG_START_Y:     start_y = sd;
                REG_RIGHT_LIMIT: right_limit = sd;
                REG_GLYPH_SCALE: scale = data[23:0];
                REG_LINE_HEIGHT: line_h = data[7:0];
                default: ;
            endcase
        endfunction

        function void push_vertex(longint x, longint y, logic [12:0] tx, logic [12:0] ty,
                                  logic lst);
            vertex_t v;
            v.x   = x[31:0];
            v.y   = y[31:0];
            v.tx  = tx;
            v.ty  = ty;
            v.lst = lst;
            quads.insert(quads.size(), v);
        endfunction

        // Update pen and table for one accepted item; queue the quad of a glyph
        function void note_item(logic [1:0] m, logic [7:0] code, glq_entry_t ent);
            glq_entry_t  g;
            longint      adv;
            longint      ox;
            longint      oy;
            longint      w;
            longint      h;
            longint      left;
            longint      right;
            longint      up;
            longint      down;
            logic [12:0] tl;
            logic [12:0] tr;
            logic [12:0] tu;
            logic [12:0] td;
            if (m == MODE_LOAD)
            begin
                glyphs[code] = ent;
                return;
            end
            if (m == MODE_START)
            begin
                pen_x = start_x;
                pen_y = start_y;
                return;
            end
            if (m != MODE_CHAR)
            begin
                return;
            end
            if (code == NEWLINE_CODE)
            begin
                line_feed();
                return;
            end
            g   = glyphs[code];
            adv = g.adv;
            ox  = $signed(g.ox);
            oy  = $signed(g.oy);
            w   = g.w;
            h   = g.h;
            // Wrap test is exact, before any clamping
            if (pen_x + scale * adv > right_limit)
            begin
                line_feed();
            end
            left  = clamp32(pen_x + scale * ox);
            up    = clamp32(pen_y - scale * oy);
            right = clamp32(left + scale * w);
            down  = clamp32(up - scale * h);
            tl = g.ax;
            tr = g.ax + g.w;
            tu = g.ay;
            td = g.ay + g.h;
            push_vertex(left, up, tl, tu, 1'b0);
            push_vertex(right, up, tr, tu, 1'b0);
            push_vertex(left, down, tl, td, 1'b0);
            push_vertex(left, down, tl, td, 1'b0);
            push_vertex(right, down, tr, td, 1'b0);
            push_vertex(right, up, tr, tu, 1'b1);
            pen_x = clamp32(pen_x + scale * adv);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50)
            begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
        endtask

        // Compare one vertex against the oldest one owed
        task check_vertex(logic signed [31:0] x, logic signed [31:0] y, logic [12:0] tx,
                          logic [12:0] ty, logic lst);
            vertex_t e;
            if (quads.size() == 0)
            begin
                report($sformatf("vertex with none owed x=%h y=%h", x, y));
                return;
            end
            e = quads.pop_front();
            if (x !== e.x)
            begin
                report($sformatf("pos_x %h, wanted %h", x, e.x));
            end
            if (y !== e.y)
            begin
                report($sformatf("pos_y %h, wanted %h", y, e.y));
            end
            if (tx !== e.tx)
            begin
                report($sformatf("tex_x %0d, wanted %0d", tx, e.tx));
            end
            if (ty !== e.ty)
            begin
                report($sformatf("tex_y %0d, wanted %0d", ty, e.ty));
            end
            if (lst !== e.lst)
            begin
                report($sformatf("last %b, wanted %b", lst, e.lst));
            end
        endtask
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [1:0]            mode         = '0;
    logic [7:0]            char_code    = '0;
    logic [11:0]           atlas_x      = '0;
    logic [11:0]           atlas_y      = '0;
    logic [7:0]            glyph_width  = '0;
    logic [7:0]            glyph_height = '0;
    logic signed [7:0]     offset_x     = '0;
    logic signed [7:0]     offset_y     = '0;
    logic [7:0]            advance      = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic signed [31:0]    pos_x;
    logic signed [31:0]    pos_y;
    logic [12:0]           tex_x;
    logic [12:0]           tex_y;
    logic                  last;

    quad_scoreboard sb = new();
    bit             calm = 1'b0;
    bit             long_hold = 1'b0;
    int             items_sent = 0;
    int             idle_cycles = 0;
    bit             loaded [256];
    logic [7:0]     loaded_codes [$];

    wire in_fire  = in_valid && in_ready;
    wire out_fire = out_valid && out_ready;
    wire cfg_fire = cfg_valid && cfg_ready;

    glyph_quad_layout u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .char_code    (char_code),
        .atlas_x      (atlas_x),
        .atlas_y      (atlas_y),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .tex_x        (tex_x),
        .tex_y        (tex_y),
        .last         (last)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Track every handshake at the edge where it happens
    always @(posedge clk)
    begin
        if (rst_n && cfg_fire)
        begin
            sb.write_reg(cfg_index, cfg_data);
        end
        if (rst_n && in_fire)
        begin
            sb.note_item(mode, char_code, glq_entry_t'({atlas_x, atlas_y, glyph_width,
                         glyph_height, offset_x, offset_y, advance}));
        end
        if (rst_n && out_fire)
        begin
            sb.check_vertex(pos_x, pos_y, tex_x, tex_y, last);
        end
    end

    // Abort when no channel moves an item for too long
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !(in_fire || out_fire || cfg_fire))
            begin
                idle_cycles++;
            end
            else
            begin
                idle_cycles = 0;
            end
        end
        $display("FAIL");
        $finish;
    end

    // Vertex receiver: random stall bursts, one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic glq_entry_t rand_entry();
        glq_entry_t e;
        e = {$urandom(), $urandom()};
        return e;
    endfunction

    // Pick a loaded table entry; glyphs never use the newline code
    function automatic logic [7:0] glyph_code(bit allow_newline);
        logic [7:0] c;
        c = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
        while (!allow_newline && c == NEWLINE_CODE)
        begin
            c = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
        end
        return c;
    endfunction

    // Offer one item, hold it until taken, then maybe idle a burst
    task automatic send_item(logic [1:0] m, logic [7:0] code, glq_entry_t ent);
        in_valid     <= 1'b1;
        mode         <= m;
        char_code    <= code;
        atlas_x      <= ent.ax;
        atlas_y      <= ent.ay;
        glyph_width  <= ent.w;
        glyph_height <= ent.h;
        offset_x     <= ent.ox;
        offset_y     <= ent.oy;
        advance      <= ent.adv;
        if (m == MODE_LOAD && !loaded[code])
        begin
            loaded[code] = 1'b1;
            loaded_codes.insert(loaded_codes.size(), code);
        end
        if (m != MODE_UNUSED)
        begin
            items_sent++;
        end
        do
            @(posedge clk);
        while (!in_ready);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Drain all owed vertices and let items with no output leave the pipe
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_config(logic [31:0] sx, logic [31:0] sy, logic [31:0] rl,
                                  logic [31:0] gs, logic [31:0] lh);
        settle();
        cfg_write(REG_START_X, sx);
        cfg_write(REG_START_Y, sy);
        cfg_write(REG_RIGHT_LIMIT, rl);
        cfg_write(REG_GLYPH_SCALE, gs);
        cfg_write(REG_LINE_HEIGHT, lh);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        int          phase;
        int          burst;
        int          k;
        int unsigned sel;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] rl;
        logic [31:0] gs;
        logic [31:0] lh;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unit scale, no right bound
        program_config(32'd0, 32'd0, INT_MAX, 32'd65536, 32'd16);
        send_item(MODE_LOAD, NEWLINE_CODE, rand_entry());
        send_item(MODE_LOAD, 8'd65, glq_entry_t'(64'd0));
        send_item(MODE_LOAD, 8'd255,
                  glq_entry_t'({12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'h80, 8'h7F, 8'hFF}));
        send_item(MODE_LOAD, 8'd0,
                  glq_entry_t'({12'hAAA, 12'h555, 8'h55, 8'hAA, 8'h7F, 8'h80, 8'h80}));
        send_item(MODE_START, 8'd65, rand_entry());
        send_item(MODE_CHAR, 8'd65, rand_entry());
        send_item(MODE_CHAR, 8'd255, rand_entry());
        send_item(MODE_CHAR, 8'd0, rand_entry());
        send_item(MODE_CHAR, NEWLINE_CODE, rand_entry());
        send_item(MODE_CHAR, 8'd255, rand_entry());
        send_item(MODE_UNUSED, 8'd0, rand_entry());
        send_item(MODE_CHAR, 8'd0, rand_entry());

        // Largest scale near the top edge: wraps, saturation of pen and corners
        program_config(32'h7FFF_0000, INT_MIN, INT_MAX, 32'h00FF_FFFF, 32'd255);
        send_item(MODE_START, 8'd0, rand_entry());
        send_item(MODE_CHAR, 8'd255, rand_entry());
        send_item(MODE_CHAR, 8'd0, rand_entry());
        send_item(MODE_CHAR, NEWLINE_CODE, rand_entry());
        send_item(MODE_CHAR, 8'd0, rand_entry());

        // Zero scale with the lowest bound: the pen sits on the bound and no glyph wraps
        program_config(INT_MIN, INT_MAX, INT_MIN, 32'd0, 32'd0);
        send_item(MODE_START, 8'd255, rand_entry());
        send_item(MODE_CHAR, 8'd255, rand_entry());
        send_item(MODE_CHAR, 8'd0, rand_entry());
        send_item(MODE_CHAR, NEWLINE_CODE, rand_entry());

        // Random strings, each under a fresh setting
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= CALM_FROM)
            begin
                calm = 1'b1;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                sx = $urandom_range(0, 1) ? INT_MIN : INT_MAX;
                sy = $urandom_range(0, 1) ? INT_MIN : INT_MAX;
                rl = $urandom_range(0, 1) ? INT_MIN : INT_MAX;
                gs = $urandom_range(0, 1) ? 32'd0 : 32'h00FF_FFFF;
                lh = $urandom_range(0, 1) ? 32'd0 : 32'd255;
            end
            else
            begin
                sx = $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
                sy = $urandom();
                rl = sx + $urandom_range(0, 32'h0200_0000);
                gs = ($urandom() & 32'hFF00_0000) | $urandom_range(32'h8000, 32'h3_0000);
                lh = ($urandom() & 32'hFFFF_FF00) | $urandom_range(0, 255);
            end
            program_config(sx, sy, rl, gs, lh);

            // Fill the block while the receiver holds off
            if (phase == 1)
            begin
                long_hold = 1'b1;
            end
            send_item(MODE_START, glyph_code(1'b1), rand_entry());
            burst = (phase == 1) ? 60 : $urandom_range(15, 40);
            for (k = 0; k < burst; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 68)
                begin
                    send_item(MODE_CHAR, glyph_code(1'b0), rand_entry());
                end
                else if (sel < 80)
                begin
                    send_item(MODE_CHAR, NEWLINE_CODE, rand_entry());
                end
                else if (sel < 90)
                begin
                    send_item(MODE_LOAD, 8'($urandom_range(0, 255)), rand_entry());
                end
                else if (sel < 95)
                begin
                    send_item(MODE_START, glyph_code(1'b1), rand_entry());
                end
                else
                begin
                    send_item(MODE_UNUSED, glyph_code(1'b1), rand_entry());
                end
            end
            phase++;
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/glq_pkg.sv
rtl/core/glq_table.sv
rtl/core/glq_scale.sv
rtl/core/glq_pen.sv
rtl/core/glq_vertex.sv
rtl/core/glyph_quad_layout.sv
rtl/core/glq_checker.sv
dv/tb_glyph_quad_layout.sv
